// File: hdl/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition at one edge implies a condition at the next edge
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: hdl/clcd_pkg.sv
// types, constants and nibble tables for the character display byte stream
package clcd_pkg;

   localparam logic [1:0] OP_BEGIN = 2'd0;
   localparam logic [1:0] OP_CHAR  = 2'd1;
   localparam logic [1:0] OP_INIT  = 2'd2;

   localparam logic [7:0] CHAR_END        = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;
   localparam logic [7:0] CHAR_LAST_PRINT  = 8'h7E;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;

   localparam logic [7:0] BIT_BACKLIGHT = 8'h08;
   localparam logic [7:0] BIT_ENABLE    = 8'h04;
   localparam logic [7:0] BIT_RS        = 8'h01;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
   localparam logic [7:0] ROW1_BASE        = 8'h40;

   localparam logic [3:0] NIB_WAKE  = 4'h3;
   localparam logic [3:0] NIB_4BIT  = 4'h2;

   localparam int JOB_QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] expander_byte;
      logic       last;
   } rsp_type;

   typedef enum logic [2:0] {
      JOB_INIT,
      JOB_BEGIN,
      JOB_ADDR,
      JOB_CHAR,
      JOB_ADDR_CHAR
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   ch;
   } job_type;

   typedef struct packed {
      logic       rs;
      logic [3:0] nibble;
   } nib_sel_type;

   typedef enum logic [1:0] {
      PHASE_SETUP,
      PHASE_STROBE,
      PHASE_HOLD
   } phase_type;

   function automatic logic [3:0] job_nibbles(job_kind_type kind);
      logic [3:0] n;
      unique case (kind)
         JOB_INIT:      n = 4'd14;
         JOB_BEGIN:     n = 4'd4;
         JOB_ADDR:      n = 4'd2;
         JOB_CHAR:      n = 4'd2;
         JOB_ADDR_CHAR: n = 4'd4;
         default:       n = 4'd1;
      endcase
      return n;
   endfunction

   function automatic nib_sel_type job_nibble(job_kind_type kind, logic [3:0] idx,
                                              logic [7:0] ch);
      logic [7:0]  cmd;
      logic        single;
      nib_sel_type r;
      cmd      = CMD_SET_ADDR | ROW1_BASE;
      single   = 1'b0;
      r.rs     = 1'b0;
      r.nibble = NIB_WAKE;
      unique case (kind)
         JOB_INIT: begin
            case (idx) inside
               4'd0, 4'd1, 4'd2: begin
                  single   = 1'b1;
                  r.nibble = NIB_WAKE;
               end
               4'd3: begin
                  single   = 1'b1;
                  r.nibble = NIB_4BIT;
               end
               4'd4, 4'd5:   cmd = CMD_FUNCTION_SET;
               4'd6, 4'd7:   cmd = CMD_DISPLAY_OFF;
               4'd8, 4'd9:   cmd = CMD_CLEAR;
               4'd10, 4'd11: cmd = CMD_ENTRY_MODE;
               default:      cmd = CMD_DISPLAY_ON;
            endcase
         end
         JOB_BEGIN:     cmd = idx[1] ? CMD_SET_ADDR : CMD_CLEAR;
         JOB_ADDR:      cmd = CMD_SET_ADDR | ROW1_BASE;
         JOB_CHAR: begin
            cmd  = ch;
            r.rs = 1'b1;
         end
         JOB_ADDR_CHAR: begin
            cmd  = idx[1] ? ch : (CMD_SET_ADDR | ROW1_BASE);
            r.rs = idx[1];
         end
         default:       cmd = CMD_SET_ADDR | ROW1_BASE;
      endcase
      if (!single) begin
         r.nibble = idx[0] ? cmd[3:0] : cmd[7:4];
      end
      return r;
   endfunction

endpackage

// File: hdl/char_lcd_text_to_expander_bytes.sv
// top level: character display text to i2c port expander byte stream
// Takes begin, character and initialize items and emits the expander bytes that drive a
// 4-bit character display, three bytes per nibble at one byte per cycle while the receiver
// keeps popping. A character emits 6 bytes, or 12 when it wraps to the next row; a newline 6,
// begin 12, initialize 42; items that emit nothing queue no job. The back end byte sequencer
// sets this pace, and a two-entry job queue lets the front end take the next item while bytes
// of earlier items still go out. The last flag marks the final byte of each emitting item.
module char_lcd_text_to_expander_bytes #(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  clcd_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output clcd_pkg::rsp_type rsp_data
);
   import clcd_pkg::*;

   logic    queue_full;
   logic    job_push;
   job_type job_in;
   logic    job_valid;
   job_type job_head;
   logic    job_pop;

   clcd_front #(
      .COLUMNS(COLUMNS),
      .ROWS(ROWS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .queue_full(queue_full),
      .job_push(job_push),
      .job_data(job_in)
   );

   clcd_job_queue u_queue (
      .clock(clock),
      .reset(reset),
      .job_push(job_push),
      .job_in(job_in),
      .queue_full(queue_full),
      .job_valid(job_valid),
      .job_head(job_head),
      .job_pop(job_pop)
   );

   clcd_back u_back (
      .clock(clock),
      .reset(reset),
      .job_valid(job_valid),
      .job_head(job_head),
      .job_pop(job_pop),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

endmodule

// File: hdl/clcd_front.sv
// front end: accepts items, tracks the cursor and queues byte-stream jobs
`include "assert_macros.svh"

module clcd_front #(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  clcd_pkg::req_type req_data,
   input  logic             queue_full,
   output logic             job_push,
   output clcd_pkg::job_type job_data
);
   import clcd_pkg::*;

   localparam int COL_W = $clog2(COLUMNS + 1);
   localparam int ROW_W = $clog2(ROWS + 1);

   logic [ROW_W-1:0] cursor_row_ff, cursor_row_in;
   logic [COL_W-1:0] cursor_column_ff, cursor_column_in;
   logic             accept;
   logic             job_valid;
   logic [ROW_W:0]   row_next;
   logic             rows_done;
   logic [7:0]       print_ch;

   assign full     = queue_full;
   assign accept   = push && !queue_full;
   assign job_push = accept && job_valid;
   assign row_next = {1'b0, cursor_row_ff} + (ROW_W + 1)'(1);
   assign rows_done = row_next >= (ROW_W + 1)'(ROWS);

   always_comb begin
      print_ch = req_data.char_code;
      if (req_data.char_code < CHAR_FIRST_PRINT || req_data.char_code > CHAR_LAST_PRINT) begin
         print_ch = CHAR_SPACE;
      end
   end

   always_comb begin
      cursor_row_in    = cursor_row_ff;
      cursor_column_in = cursor_column_ff;
      job_valid        = 1'b0;
      job_data.kind    = JOB_CHAR;
      job_data.ch      = print_ch;
      unique case (req_data.op)
         OP_INIT: begin
            job_valid        = 1'b1;
            job_data.kind    = JOB_INIT;
            cursor_row_in    = '0;
            cursor_column_in = '0;
         end
         OP_BEGIN: begin
            job_valid        = 1'b1;
            job_data.kind    = JOB_BEGIN;
            cursor_row_in    = '0;
            cursor_column_in = '0;
         end
         OP_CHAR: begin
            if (cursor_row_ff < ROW_W'(ROWS)) begin
               if (req_data.char_code == CHAR_END) begin
                  cursor_row_in = ROW_W'(ROWS);
               end else if (req_data.char_code == CHAR_NEWLINE) begin
                  if (rows_done) begin
                     cursor_row_in = ROW_W'(ROWS);
                  end else begin
                     cursor_row_in    = row_next[ROW_W-1:0];
                     cursor_column_in = '0;
                     job_valid        = 1'b1;
                     job_data.kind    = JOB_ADDR;
                  end
               end else if (cursor_column_ff >= COL_W'(COLUMNS)) begin
                  if (rows_done) begin
                     cursor_row_in = ROW_W'(ROWS);
                  end else begin
                     cursor_row_in    = row_next[ROW_W-1:0];
                     cursor_column_in = COL_W'(1);
                     job_valid        = 1'b1;
                     job_data.kind    = JOB_ADDR_CHAR;
                  end
               end else begin
                  cursor_column_in = cursor_column_ff + COL_W'(1);
                  job_valid        = 1'b1;
                  job_data.kind    = JOB_CHAR;
               end
            end
         end
         default: begin
            job_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_row_ff    <= '0;
         cursor_column_ff <= '0;
      end else if (accept) begin
         cursor_row_ff    <= cursor_row_in;
         cursor_column_ff <= cursor_column_in;
      end
   end

   `ASSERT_ALWAYS(a_row_range, clock, reset, cursor_row_ff <= ROW_W'(ROWS), "cursor row out of range")
   `ASSERT_ALWAYS(a_col_range, clock, reset, cursor_column_ff <= COL_W'(COLUMNS), "cursor column out of range")
   `ASSERT_ALWAYS(a_closed_text, clock, reset, !(job_push && req_data.op == OP_CHAR && cursor_row_ff == ROW_W'(ROWS)), "job queued after text closed")

endmodule

// File: hdl/clcd_job_queue.sv
// short job queue between the front end and the byte sequencer
`include "assert_macros.svh"

module clcd_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_push,
   input  clcd_pkg::job_type job_in,
   output logic             queue_full,
   output logic             job_valid,
   output clcd_pkg::job_type job_head,
   input  logic             job_pop
);
   import clcd_pkg::*;

   localparam int PTR_W = $clog2(JOB_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type          entry_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign queue_full = count_ff == CNT_W'(JOB_QUEUE_DEPTH);
   assign job_valid  = count_ff != '0;
   assign job_head   = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (job_push && !job_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (job_pop && !job_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (job_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (job_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   `ASSERT_ALWAYS(a_no_overflow, clock, reset, !(job_push && queue_full && !job_pop), "job queue overflow")
   `ASSERT_ALWAYS(a_no_underflow, clock, reset, !(job_pop && !job_valid), "job queue underflow")

endmodule

// File: hdl/clcd_back.sv
// byte sequencer: expands a job into expander bytes, one per cycle unless the receiver stalls
`include "assert_macros.svh"

module clcd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   input  clcd_pkg::job_type job_head,
   output logic             job_pop,
   output logic             empty,
   input  logic             pop,
   output clcd_pkg::rsp_type rsp_data
);
   import clcd_pkg::*;

   logic [3:0]  nib_idx_ff, nib_idx_in;
   phase_type   phase_ff, phase_in;
   logic        out_valid_ff, out_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic        advance;
   logic        last_nib;
   nib_sel_type sel;
   logic [7:0]  base_byte;

   assign advance   = job_valid && (!out_valid_ff || pop);
   assign sel       = job_nibble(job_head.kind, nib_idx_ff, job_head.ch);
   assign base_byte = {sel.nibble, 4'h0} | BIT_BACKLIGHT | (sel.rs ? BIT_RS : 8'h00);
   assign last_nib  = nib_idx_ff == job_nibbles(job_head.kind) - 4'd1;
   assign job_pop   = advance && last_nib && phase_ff == PHASE_HOLD;
   assign empty     = !out_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      nib_idx_in       = nib_idx_ff;
      phase_in         = phase_ff;
      rsp_in           = rsp_ff;
      out_valid_in     = out_valid_ff;
      if (advance) begin
         out_valid_in     = 1'b1;
         rsp_in.last      = 1'b0;
         rsp_in.expander_byte = base_byte;
         unique case (phase_ff)
            PHASE_SETUP: begin
               phase_in = PHASE_STROBE;
            end
            PHASE_STROBE: begin
               rsp_in.expander_byte = base_byte | BIT_ENABLE;
               phase_in = PHASE_HOLD;
            end
            PHASE_HOLD: begin
               phase_in = PHASE_SETUP;
               if (last_nib) begin
                  nib_idx_in  = '0;
                  rsp_in.last = 1'b1;
               end else begin
                  nib_idx_in = nib_idx_ff + 4'd1;
               end
            end
            default: begin
               phase_in = PHASE_SETUP;
            end
         endcase
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nib_idx_ff   <= '0;
         phase_ff     <= PHASE_SETUP;
         out_valid_ff <= 1'b0;
      end else begin
         nib_idx_ff   <= nib_idx_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   `ASSERT_ALWAYS(a_idx_in_job, clock, reset, !job_valid || nib_idx_ff < job_nibbles(job_head.kind), "nibble index past end of job")
   `ASSERT_NEXT(a_last_pops, clock, reset, job_pop, out_valid_ff && rsp_ff.last && phase_ff == PHASE_SETUP && nib_idx_ff == 4'd0, "job popped without last byte")

endmodule

// File: sim/tb.sv
// testbench for the character display text to expander byte stream block
`timescale 1ns / 100ps

module tb;
   import clcd_pkg::*;

   localparam int DISPLAY_ROWS    = 2;
   localparam int DISPLAY_COLUMNS = 16;
   localparam int HOLD_CYCLES     = 250;
   localparam int SETTLE_CYCLES   = 60;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   rsp_type expected_bytes[$];
   int      text_row = 0;
   int      text_column = 0;
   int      mismatch_count = 0;
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   int      hold_requests = 0;
   int      holds_served = 0;
   int      hold_left = 0;

   char_lcd_text_to_expander_bytes #(
      .COLUMNS(DISPLAY_COLUMNS),
      .ROWS(DISPLAY_ROWS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_data(req_data),
      .empty(empty),
      .pop(pop),
      .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic void queue_nibble(logic [3:0] nib, logic rs);
      logic [7:0] b;
      b = {nib, 4'h0} | BIT_BACKLIGHT | (rs ? BIT_RS : 8'h00);
      expected_bytes.push_back('{expander_byte: b, last: 1'b0});
      expected_bytes.push_back('{expander_byte: b | BIT_ENABLE, last: 1'b0});
      expected_bytes.push_back('{expander_byte: b & ~BIT_ENABLE, last: 1'b0});
   endfunction

   function automatic void queue_byte(logic [7:0] v, logic rs);
      queue_nibble(v[7:4], rs);
      queue_nibble(v[3:0], rs);
   endfunction

   function automatic bit advance_row();
      if (text_row + 1 >= DISPLAY_ROWS) begin
         text_row = DISPLAY_ROWS;
         return 1'b0;
      end
      text_row++;
      text_column = 0;
      queue_byte(text_row == 0 ? CMD_SET_ADDR : (CMD_SET_ADDR | ROW1_BASE), 1'b0);
      return 1'b1;
   endfunction

   function automatic void predict_expander_bytes(req_type item);
      int         count_before;
      logic [7:0] code;
      rsp_type    tail;
      count_before = expected_bytes.size();
      code = item.char_code;
      case (item.op)
         OP_INIT: begin
            queue_nibble(NIB_WAKE, 1'b0);
            queue_nibble(NIB_WAKE, 1'b0);
            queue_nibble(NIB_WAKE, 1'b0);
            queue_nibble(NIB_4BIT, 1'b0);
            queue_byte(CMD_FUNCTION_SET, 1'b0);
            queue_byte(CMD_DISPLAY_OFF, 1'b0);
            queue_byte(CMD_CLEAR, 1'b0);
            queue_byte(CMD_ENTRY_MODE, 1'b0);
            queue_byte(CMD_DISPLAY_ON, 1'b0);
            text_row = 0;
            text_column = 0;
         end
         OP_BEGIN: begin
            queue_byte(CMD_CLEAR, 1'b0);
            queue_byte(CMD_SET_ADDR, 1'b0);
            text_row = 0;
            text_column = 0;
         end
         OP_CHAR: begin
            if (text_row < DISPLAY_ROWS) begin
               if (code == CHAR_END) begin
                  text_row = DISPLAY_ROWS;
               end else if (code == CHAR_NEWLINE) begin
                  void'(advance_row());
               end else if (text_column < DISPLAY_COLUMNS || advance_row()) begin
                  if (code < CHAR_FIRST_PRINT || code > CHAR_LAST_PRINT) begin
                     code = CHAR_SPACE;
                  end
                  queue_byte(code, 1'b1);
                  text_column++;
               end
            end
         end
         default: ;
      endcase
      if (expected_bytes.size() > count_before) begin
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (holds_served != hold_requests) begin
         holds_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t unexpected transfer: byte %h last %b", $time,
                     rsp_data.expander_byte, rsp_data.last);
            mismatch_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.expander_byte !== want.expander_byte) begin
               $display("%0t expander_byte mismatch: expected %h actual %h", $time,
                        want.expander_byte, rsp_data.expander_byte);
               mismatch_count++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t last mismatch: expected %b actual %b", $time,
                        want.last, rsp_data.last);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_text_item(logic [1:0] op, logic [7:0] code);
      req_type item;
      item = '{op: op, char_code: code};
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      predict_expander_bytes(item);
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] random_text_char();
      int pick;
      pick = $urandom_range(99);
      if (pick < 75) return 8'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_PRINT));
      if (pick < 85) return CHAR_NEWLINE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic test_directed_cases();
      send_text_item(OP_INIT, 8'h00);
      send_text_item(OP_BEGIN, 8'hFF);
      send_text_item(OP_CHAR, 8'h41);
      send_text_item(OP_CHAR, CHAR_FIRST_PRINT);
      send_text_item(OP_CHAR, CHAR_LAST_PRINT);
      send_text_item(OP_CHAR, 8'h1F);
      send_text_item(OP_CHAR, 8'h7F);
      send_text_item(OP_CHAR, 8'hFF);
      send_text_item(OP_CHAR, 8'h80);
      send_text_item(OP_CHAR, 8'h01);
      send_text_item(OP_CHAR, CHAR_NEWLINE);
      send_text_item(OP_UNUSED, 8'hFF);
      send_text_item(OP_CHAR, 8'h5A);
      send_text_item(OP_CHAR, CHAR_NEWLINE);
      send_text_item(OP_CHAR, 8'h42);
      send_text_item(OP_CHAR, CHAR_NEWLINE);
      send_text_item(OP_BEGIN, 8'h00);
      send_text_item(OP_CHAR, CHAR_END);
      send_text_item(OP_CHAR, 8'h43);
      send_text_item(OP_UNUSED, 8'h00);
      send_text_item(OP_BEGIN, 8'h00);
      send_text_item(OP_CHAR, 8'h61);
      wait_drained();
   endtask

   // fill both rows and run past the end so the wrap and the drop both happen
   task automatic test_row_wrap();
      send_text_item(OP_BEGIN, 8'h00);
      repeat (2 * DISPLAY_COLUMNS + 3) begin
         send_text_item(OP_CHAR, 8'($urandom_range(CHAR_FIRST_PRINT, CHAR_LAST_PRINT)));
      end
      wait_drained();
   endtask

   task automatic test_receiver_hold();
      send_idle_pct <= 0;
      stall_pct <= 0;
      hold_requests <= hold_requests + 1;
      send_text_item(OP_INIT, 8'h00);
      send_text_item(OP_BEGIN, 8'h00);
      repeat (30) send_text_item(OP_CHAR, random_text_char());
      wait_drained();
   endtask

   task automatic test_random_text(int send_idle, int stall, int item_budget);
      int sent;
      int text_length;
      sent = 0;
      send_idle_pct <= send_idle;
      stall_pct <= stall;
      while (sent < item_budget) begin
         if ($urandom_range(99) < 80) begin
            send_text_item($urandom_range(99) < 8 ? OP_INIT : OP_BEGIN, 8'($urandom()));
            text_length = ($urandom_range(99) < 20) ? $urandom_range(17, 40)
                                                    : $urandom_range(0, 12);
            repeat (text_length) send_text_item(OP_CHAR, random_text_char());
            if ($urandom_range(99) < 30) begin
               send_text_item(OP_CHAR, CHAR_END);
               send_text_item(OP_CHAR, random_text_char());
               sent += 2;
            end
            sent += 1 + text_length;
         end else begin
            send_text_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            sent++;
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_row_wrap();
      test_receiver_hold();
      test_random_text(0, 0, 20);
      test_random_text(56, 0, 20);
      test_random_text(0, 56, 20);
      test_random_text(29, 29, 20);
      if (mismatch_count == 0 && expected_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: char_lcd_text_to_expander_bytes.f
+incdir+hdl
hdl/clcd_pkg.sv
hdl/clcd_front.sv
hdl/clcd_job_queue.sv
hdl/clcd_back.sv
hdl/char_lcd_text_to_expander_bytes.sv
sim/tb.sv
